// File: rtl/core/iuab_pkg.sv
// Shared constants, types and the square-root step for the R-function union blend.
`default_nettype none
package iuab_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int SUM_W         = VALUE_BITS + 1;
  localparam int ATTR_W        = VALUE_BITS + 1;
  localparam int U_W           = VALUE_BITS + 2;
  localparam int SQ_W          = 2 * VALUE_BITS;

  // Two root bits per stage; the root is padded to an even width.
  localparam int SQRT_STAGES   = (VALUE_BITS + 1) / 2;
  localparam int ROOT_W        = 2 * SQRT_STAGES;
  localparam int RAD_W         = 2 * ROOT_W;
  localparam int REM_W         = ROOT_W + 3;

  localparam int SQUARE_STAGES = 3;
  localparam int BLEND_STAGES  = 2;
  localparam int LATENCY       = SQUARE_STAGES + SQRT_STAGES + BLEND_STAGES;

  localparam int MODE_W        = 3;
  localparam int EPS_W         = 16;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS_THRESHOLD = 1'b1;

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  typedef enum logic [MODE_W-1:0] {
    BLEND_FIRST  = 3'd0,
    BLEND_SECOND = 3'd1,
    BLEND_SUM    = 3'd2,
    BLEND_MIN    = 3'd3,
    BLEND_MAX    = 3'd4
  } blend_mode_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [EPS_W-1:0]  eps;
  } cfg_t;

  // Data that rides alongside the root computation.
  typedef struct packed {
    logic signed [SUM_W-1:0]      fsum;
    logic                         a_nonneg;
    logic                         b_nonneg;
    logic signed [VALUE_BITS-1:0] attr_a;
    logic signed [VALUE_BITS-1:0] attr_b;
    logic                         last;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_state_t;

  // One restoring digit-by-digit square-root step: bring down two radicand bits.
  function automatic sqrt_state_t sqrt_step(input sqrt_state_t s_in);
    sqrt_state_t      s;
    logic [REM_W-1:0] trial;
    s       = s_in;
    s.rem   = {s_in.rem[REM_W-3:0], s_in.rad[RAD_W-1 -: 2]};
    s.rad   = {s_in.rad[RAD_W-3:0], 2'b00};
    trial   = {1'b0, s_in.root, 2'b01};
    if (s.rem >= trial) begin
      s.rem  = s.rem - trial;
      s.root = {s_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      s.root = {s_in.root[ROOT_W-2:0], 1'b0};
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/iuab_square.sv
// Front stages: magnitudes, squares and the sum of squares, with side data.
`default_nettype none
module iuab_square (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  input  wire logic signed [iuab_pkg::VALUE_BITS-1:0] field_a,
  input  wire logic signed [iuab_pkg::VALUE_BITS-1:0] field_b,
  input  wire logic signed [iuab_pkg::VALUE_BITS-1:0] attr_a,
  input  wire logic signed [iuab_pkg::VALUE_BITS-1:0] attr_b,
  input  wire logic                                  last,
  output logic                                       out_valid,
  output logic [iuab_pkg::SQ_W-1:0]                  out_rad,
  output iuab_pkg::side_t                            out_side
);
  import iuab_pkg::*;

  logic                  vld_r [SQUARE_STAGES];
  side_t                 side_r [SQUARE_STAGES];
  side_t                 side_nxt;
  logic [VALUE_BITS-1:0] mag_a_nxt, mag_b_nxt;
  logic [VALUE_BITS-1:0] mag_a_r, mag_b_r;
  logic [SQ_W-1:0]       sq_a_nxt, sq_b_nxt;
  logic [SQ_W-1:0]       sq_a_r, sq_b_r;
  logic [SQ_W-1:0]       rad_r;

  always_comb begin
    mag_a_nxt         = field_a[VALUE_BITS-1] ? $unsigned(~field_a) + 1'b1 : $unsigned(field_a);
    mag_b_nxt         = field_b[VALUE_BITS-1] ? $unsigned(~field_b) + 1'b1 : $unsigned(field_b);
    side_nxt.fsum     = SUM_W'(field_a) + SUM_W'(field_b);
    side_nxt.a_nonneg = ~field_a[VALUE_BITS-1];
    side_nxt.b_nonneg = ~field_b[VALUE_BITS-1];
    side_nxt.attr_a   = attr_a;
    side_nxt.attr_b   = attr_b;
    side_nxt.last     = last;
  end

  assign sq_a_nxt = SQ_W'(mag_a_r) * SQ_W'(mag_a_r);
  assign sq_b_nxt = SQ_W'(mag_b_r) * SQ_W'(mag_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
      vld_r[1] <= 1'b0;
      vld_r[2] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      vld_r[1] <= vld_r[0];
      vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    mag_a_r   <= mag_a_nxt;
    mag_b_r   <= mag_b_nxt;
    side_r[0] <= side_nxt;
    sq_a_r    <= sq_a_nxt;
    sq_b_r    <= sq_b_nxt;
    side_r[1] <= side_r[0];
    rad_r     <= sq_a_r + sq_b_r;
    side_r[2] <= side_r[1];
  end

  assign out_valid = vld_r[SQUARE_STAGES-1];
  assign out_rad   = rad_r;
  assign out_side  = side_r[SQUARE_STAGES-1];

endmodule
`default_nettype wire

// File: rtl/core/iuab_isqrt.sv
// Pipelined integer square root, two root bits per stage, floor rounding.
`default_nettype none
module iuab_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [iuab_pkg::SQ_W-1:0]     in_rad,
  input  wire iuab_pkg::side_t               in_side,
  output logic                               out_valid,
  output logic [iuab_pkg::VALUE_BITS-1:0]    out_root,
  output iuab_pkg::side_t                    out_side
);
  import iuab_pkg::*;

  logic        vld_r  [SQRT_STAGES];
  sqrt_state_t st_r   [SQRT_STAGES];
  side_t       side_r [SQRT_STAGES];
  sqrt_state_t st_nxt [SQRT_STAGES];
  sqrt_state_t st_in;

  always_comb begin
    st_in.rem  = '0;
    st_in.root = '0;
    st_in.rad  = RAD_W'(in_rad);
  end

  // Each stage resolves two root bits from the state of the stage before it.
  always_comb begin
    st_nxt[0] = sqrt_step(sqrt_step(st_in));
    for (int i = 1; i < SQRT_STAGES; i++) begin
      st_nxt[i] = sqrt_step(sqrt_step(st_r[i-1]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQRT_STAGES; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int i = 0; i < SQRT_STAGES; i++) begin
      st_r[i] <= st_nxt[i];
    end
    for (int i = 1; i < SQRT_STAGES; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign out_root  = st_r[SQRT_STAGES-1].root[VALUE_BITS-1:0];
  assign out_side  = side_r[SQRT_STAGES-1];

  // A finished root leaves a remainder no larger than twice the root.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQRT_STAGES-1] |->
      (st_r[SQRT_STAGES-1].rem <= REM_W'({st_r[SQRT_STAGES-1].root, 1'b0})))
    else $error("square root remainder out of range");

  // The root bits above the field width never get set.
  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQRT_STAGES-1] |->
      (st_r[SQRT_STAGES-1].root >> VALUE_BITS) == '0)
    else $error("square root wider than field");

endmodule
`default_nettype wire

// File: rtl/core/iuab_blend.sv
// Back stages: union value, threshold test and attribute blend, output register.
`default_nettype none
module iuab_blend (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic [iuab_pkg::VALUE_BITS-1:0]    in_root,
  input  wire iuab_pkg::side_t                    in_side,
  input  wire iuab_pkg::cfg_t                     cfg,
  output logic                                    out_valid,
  output logic signed [iuab_pkg::U_W-1:0]         union_value,
  output logic signed [iuab_pkg::ATTR_W-1:0]      attr_out,
  output logic                                    attr_written,
  output logic                                    last_out
);
  import iuab_pkg::*;

  logic                     vld_u_r, vld_o_r;
  logic signed [U_W-1:0]    u_nxt, u_r;
  side_t                    side_u_r;
  logic signed [U_W:0]      margin;
  logic                     pass;
  logic signed [ATTR_W-1:0] ca, cb;
  logic signed [ATTR_W-1:0] attr_nxt, attr_r;
  logic                     wr_nxt, wr_r;
  logic signed [U_W-1:0]    union_r;
  logic                     last_r;

  assign u_nxt = U_W'(in_side.fsum) + $signed(U_W'(in_root));

  always_comb begin
    margin   = (U_W+1)'(u_r) + $signed((U_W+1)'(cfg.eps));
    pass     = !margin[U_W] && (margin != '0);
    ca       = ATTR_W'(side_u_r.attr_a);
    cb       = ATTR_W'(side_u_r.attr_b);
    attr_nxt = '0;
    wr_nxt   = 1'b0;
    if (pass) begin
      if (side_u_r.a_nonneg && !side_u_r.b_nonneg) begin
        attr_nxt = ca;
        wr_nxt   = 1'b1;
      end else if (side_u_r.b_nonneg && !side_u_r.a_nonneg) begin
        attr_nxt = cb;
        wr_nxt   = 1'b1;
      end else begin
        wr_nxt = 1'b1;
        case (cfg.mode)
          BLEND_FIRST:  attr_nxt = ca;
          BLEND_SECOND: attr_nxt = cb;
          BLEND_SUM:    attr_nxt = ca + cb;
          BLEND_MIN:    attr_nxt = (ca > cb) ? cb : ca;
          BLEND_MAX:    attr_nxt = (ca > cb) ? ca : cb;
          default:      wr_nxt   = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_u_r <= 1'b0;
      vld_o_r <= 1'b0;
    end else begin
      vld_u_r <= in_valid;
      vld_o_r <= vld_u_r;
    end
  end

  always_ff @(posedge clk) begin
    u_r      <= u_nxt;
    side_u_r <= in_side;
    union_r  <= u_r;
    attr_r   <= attr_nxt;
    wr_r     <= wr_nxt;
    last_r   <= side_u_r.last;
  end

  assign out_valid    = vld_o_r;
  assign union_value  = union_r;
  assign attr_out     = attr_r;
  assign attr_written = wr_r;
  assign last_out     = last_r;

  // A component that is not written reads as zero.
  a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_o_r && !wr_r) |-> (attr_r == '0))
    else $error("unwritten component is not zero");

endmodule
`default_nettype wire

// File: rtl/core/implicit_union_attribute_blend.sv
// A start transfer yields an out_valid strobe once it has passed the square, root and blend stages, in that order.
// Throughput: one item per cycle; busy stays low, so start may be high every cycle.
// The root pipeline (16 stages, two root bits each) is the deepest of the three parts; there is no stall.
// Reset (synchronous, rst_n low) clears all pipeline valid bits, blend_mode to first
// and eps_threshold to 1; the configuration port is always ready.
`default_nettype none
module implicit_union_attribute_blend (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [iuab_pkg::VALUE_BITS-1:0] in_field_a,
  input  wire logic signed [iuab_pkg::VALUE_BITS-1:0] in_field_b,
  input  wire logic signed [iuab_pkg::VALUE_BITS-1:0] in_attr_a,
  input  wire logic signed [iuab_pkg::VALUE_BITS-1:0] in_attr_b,
  input  wire logic                                  in_last_component,
  output logic                                       out_valid,
  output logic signed [iuab_pkg::U_W-1:0]            out_union_value,
  output logic signed [iuab_pkg::ATTR_W-1:0]         out_attr_out,
  output logic                                       out_attr_written,
  output logic                                       out_last_out,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [iuab_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [iuab_pkg::EPS_W-1:0]            cfg_data
);
  import iuab_pkg::*;

  logic                  in_fire;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [EPS_W-1:0]      eps_r, eps_nxt;
  cfg_t                  cfg;

  logic                  sq_valid;
  logic [SQ_W-1:0]       sq_rad;
  side_t                 sq_side;
  logic                  rt_valid;
  logic [VALUE_BITS-1:0] rt_root;
  side_t                 rt_side;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;

  always_comb begin
    mode_nxt = mode_r;
    eps_nxt  = eps_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLEND_MODE:    mode_nxt = cfg_data[MODE_W-1:0];
        CFG_EPS_THRESHOLD: eps_nxt  = cfg_data;
        default:           mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_W'(BLEND_FIRST);
      eps_r  <= EPS_RESET;
    end else begin
      mode_r <= mode_nxt;
      eps_r  <= eps_nxt;
    end
  end

  assign cfg.mode = mode_r;
  assign cfg.eps  = eps_r;

  iuab_square u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_fire),
    .field_a   (in_field_a),
    .field_b   (in_field_b),
    .attr_a    (in_attr_a),
    .attr_b    (in_attr_b),
    .last      (in_last_component),
    .out_valid (sq_valid),
    .out_rad   (sq_rad),
    .out_side  (sq_side)
  );

  iuab_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_rad    (sq_rad),
    .in_side   (sq_side),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  iuab_blend u_blend (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (rt_valid),
    .in_root      (rt_root),
    .in_side      (rt_side),
    .cfg          (cfg),
    .out_valid    (out_valid),
    .union_value  (out_union_value),
    .attr_out     (out_attr_out),
    .attr_written (out_attr_written),
    .last_out     (out_last_out)
  );

  // Every accepted item comes out after the fixed pipeline latency.
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##LATENCY out_valid)
    else $error("result missing after pipeline latency");

endmodule
`default_nettype wire
